// ===== hw/rtl/oahi_pkg.sv =====
// Shared types for the open-address hash insert block: word formats,
// function and status codes, controller states and control/status bundles.
// No dependencies.
package oahi_pkg;

    // Table geometry; the word formats below are sized for these values.
    localparam int TABLE_SLOTS    = 541;
    localparam int MAX_NAME_BYTES = 9;

    typedef enum logic [1:0] {
        FUNC_NAME  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_TOO_LONG = 2'd2,
        STAT_DONE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] name_char;
        logic       last;
        logic [9:0] read_slot;
        logic [3:0] char_pos;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [9:0]  probes;
        logic        occupied;
        logic [15:0] collisions;
        logic [7:0]  name_byte;
    } result_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SQ,
        S_LD,
        S_MOD,
        S_PRB_RD,
        S_PRB_CHK,
        S_RD,
        S_RD_DATA,
        S_RESP
    } state_t;

    typedef struct packed {
        logic acc_name;
        logic acc_read;
        logic sq_load;
        logic mod_load;
        logic mod_step;
        logic probe_init;
        logic probe_rd;
        logic probe_wr;
        logic slot_rd;
        logic clr_init;
        logic clr_wr;
        logic name_done;
        logic res_too_long;
        logic res_ins;
        logic res_full;
        logic res_read;
        logic res_clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic name_last;
        logic too_long;
        logic slot_free;
        logic probe_last;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/open_address_hash_insert.sv =====
// Open-address hash table of short names. A name byte is accepted, the hash
// squared (kept as is in linear mode) and added to the byte, then reduced
// modulo TABLE_SLOTS: quotient estimate, subtract, final correction. On the
// last byte of a name that fits, each probe reads the slot and then writes it
// back on the slot memory, until a free slot or TABLE_SLOTS probes (full); a
// too-long name is rejected unprobed. A read fetches the slot, forms the
// result and hands it out. After reset and for every clear word the memory is
// swept one slot a cycle while item words are stalled. A stalled receiver
// holds off the next result. Table size and name length come from oahi_pkg.
// Depends on oahi_pkg, oahi_ctrl and oahi_dp.
module open_address_hash_insert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  oahi_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output oahi_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic               cfg_data
);

    oahi_pkg::cmd_t cmd;
    oahi_pkg::sts_t sts;

    oahi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .func       (item.func),
        .item_stall (item_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    oahi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hw/rtl/oahi_ctrl.sv =====
// Controller state machine for the open-address hash insert block.
// Depends on oahi_pkg; drives oahi_dp through cmd_t and watches sts_t.
module oahi_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic [1:0]      func,
    output logic            item_stall,
    output oahi_pkg::cmd_t  cmd,
    input  oahi_pkg::sts_t  sts
);

    oahi_pkg::state_t state_reg, state_next;
    logic             clr_rsp_reg, clr_rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= oahi_pkg::S_CLR;
            clr_rsp_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_rsp_reg <= clr_rsp_next;
        end
    end

    assign item_stall = (state_reg != oahi_pkg::S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_rsp_next = clr_rsp_reg;
        cmd          = '0;
        unique case (state_reg)
            oahi_pkg::S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next   = clr_rsp_reg ? oahi_pkg::S_RESP : oahi_pkg::S_IDLE;
                    clr_rsp_next = 1'b0;
                end
            end
            oahi_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (func)
                        oahi_pkg::FUNC_NAME:
                        begin
                            cmd.acc_name = 1'b1;
                            state_next   = oahi_pkg::S_SQ;
                        end
                        oahi_pkg::FUNC_READ:
                        begin
                            cmd.acc_read = 1'b1;
                            state_next   = oahi_pkg::S_RD;
                        end
                        oahi_pkg::FUNC_CLEAR:
                        begin
                            cmd.clr_init  = 1'b1;
                            cmd.res_clear = 1'b1;
                            clr_rsp_next  = 1'b1;
                            state_next    = oahi_pkg::S_CLR;
                        end
                        default:
                        begin
                            // unknown function: drop the word
                            state_next = oahi_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            oahi_pkg::S_SQ:
            begin
                cmd.sq_load = 1'b1;
                state_next  = oahi_pkg::S_LD;
            end
            oahi_pkg::S_LD:
            begin
                cmd.mod_load = 1'b1;
                state_next   = oahi_pkg::S_MOD;
            end
            oahi_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done)
                begin
                    priority if (!sts.name_last)
                        state_next = oahi_pkg::S_IDLE;
                    else if (sts.too_long)
                    begin
                        cmd.res_too_long = 1'b1;
                        cmd.name_done    = 1'b1;
                        state_next       = oahi_pkg::S_RESP;
                    end
                    else
                    begin
                        cmd.probe_init = 1'b1;
                        state_next     = oahi_pkg::S_PRB_RD;
                    end
                end
            end
            oahi_pkg::S_PRB_RD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = oahi_pkg::S_PRB_CHK;
            end
            oahi_pkg::S_PRB_CHK:
            begin
                cmd.probe_wr = 1'b1;
                priority if (sts.slot_free)
                begin
                    cmd.res_ins   = 1'b1;
                    cmd.name_done = 1'b1;
                    state_next    = oahi_pkg::S_RESP;
                end
                else if (sts.probe_last)
                begin
                    cmd.res_full  = 1'b1;
                    cmd.name_done = 1'b1;
                    state_next    = oahi_pkg::S_RESP;
                end
                else
                    state_next = oahi_pkg::S_PRB_RD;
            end
            oahi_pkg::S_RD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = oahi_pkg::S_RD_DATA;
            end
            oahi_pkg::S_RD_DATA:
            begin
                cmd.res_read = 1'b1;
                state_next   = oahi_pkg::S_RESP;
            end
            oahi_pkg::S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = oahi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oahi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/oahi_dp.sv =====
// Datapath for the open-address hash insert block: slot memory, name buffer,
// running hash with a reciprocal modulo reducer, probe sequencer, result words.
// Depends on oahi_pkg; controlled by oahi_ctrl.
module oahi_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  oahi_pkg::item_t    item,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  oahi_pkg::cmd_t     cmd,
    output oahi_pkg::sts_t     sts,
    output logic               result_valid,
    input  logic               result_stall,
    output oahi_pkg::result_t  result
);

    localparam int TABLE_SLOTS    = oahi_pkg::TABLE_SLOTS;
    localparam int MAX_NAME_BYTES = oahi_pkg::MAX_NAME_BYTES;
    localparam int SW   = $clog2(TABLE_SLOTS);
    localparam int NW   = $clog2(TABLE_SLOTS + 1);
    localparam int LW   = $clog2(MAX_NAME_BYTES + 2);
    localparam int NB   = 8 * MAX_NAME_BYTES;
    localparam int RW   = 1 + 16 + NB;
    localparam int VW   = ((2 * SW > 8) ? 2 * SW : 8) + 1;
    localparam int MREC = (2 ** VW) / TABLE_SLOTS;
    localparam int MW   = $clog2(MREC + 1);
    localparam int KMAX = 2;
    localparam int KW   = $clog2(KMAX + 1);
    localparam logic [SW-1:0] TWO_MOD = SW'(2 % TABLE_SLOTS);

    function automatic logic [SW-1:0] modadd(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SW+1)'(TABLE_SLOTS))
            s = s - (SW+1)'(TABLE_SLOTS);
        return s[SW-1:0];
    endfunction

    // configuration
    logic hash_mode_reg;

    // name assembly
    logic [NB-1:0]  buf_reg;
    logic [LW-1:0]  len_reg;
    logic [SW-1:0]  hash_reg;
    logic [7:0]     char_reg;
    logic           last_reg;
    logic [2*SW-1:0] prod_reg;
    logic [VW-1:0]  rem_reg;
    logic [KW-1:0]  k_reg;
    logic [MW-1:0]  q_reg;
    logic [VW+MW-1:0] qprod;
    logic [VW-1:0]  qt;
    logic [VW-1:0]  rem_fix;
    logic [SW-1:0]  hash_new;

    // probing
    logic [SW-1:0]  key_reg, nmod_reg, sq_reg, odd_reg;
    logic [SW-1:0]  nmod_next, sq_next, odd_next, key_next;
    logic [NW-1:0]  n_reg;

    // read item
    logic [9:0]     rslot_reg;
    logic [3:0]     pos_reg;
    logic           rd_in_range;

    // slot memory: used, collision count, name bytes
    logic [RW-1:0]  slot_mem [TABLE_SLOTS];
    logic [RW-1:0]  rd_data_reg;
    logic           mem_we;
    logic [SW-1:0]  mem_waddr, mem_raddr;
    logic [RW-1:0]  mem_wdata;
    logic [SW-1:0]  clr_addr_reg;

    logic           rd_used;
    logic [15:0]    rd_coll;
    logic [NB-1:0]  rd_name;
    logic [NB-1:0]  new_name;
    logic [7:0]     sel_byte;

    oahi_pkg::result_t pend_reg, out_reg;
    logic              out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_mode_reg <= 1'b0;
        else if (cfg_we)
            hash_mode_reg <= cfg_data;
    end

    // remainder by reciprocal: estimate the quotient (never too high, at most one
    // short), subtract, then one final correction
    always_comb
    begin
        qprod    = (VW+MW)'(rem_reg) * (VW+MW)'(MREC);
        qt       = VW'(q_reg) * VW'(TABLE_SLOTS);
        rem_fix  = (rem_reg >= VW'(TABLE_SLOTS)) ? rem_reg - VW'(TABLE_SLOTS) : rem_reg;
        hash_new = rem_fix[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            hash_reg <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (cmd.acc_name && len_reg <= LW'(MAX_NAME_BYTES))
                len_reg <= len_reg + 1'b1;
            if (cmd.mod_load)
                k_reg <= KW'(KMAX);
            else if (cmd.mod_step && k_reg != '0)
                k_reg <= k_reg - 1'b1;
            if (cmd.mod_step && k_reg == '0)
                hash_reg <= hash_new;
            if (cmd.name_done)
            begin
                len_reg  <= '0;
                hash_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_name)
        begin
            char_reg <= item.name_char;
            last_reg <= item.last;
            for (int i = 0; i < MAX_NAME_BYTES; i++)
                if (32'(len_reg) == i)
                    buf_reg[8*i +: 8] <= item.name_char;
        end
        if (cmd.acc_read)
        begin
            rslot_reg <= item.read_slot;
            pos_reg   <= item.char_pos;
        end
        if (cmd.sq_load)
            prod_reg <= hash_mode_reg ? hash_reg * hash_reg : (2*SW)'(hash_reg);
        if (cmd.mod_step && k_reg == KW'(KMAX))
            q_reg <= qprod[VW +: MW];
        if (cmd.mod_load)
            rem_reg <= VW'(prod_reg) + VW'(char_reg);
        else if (cmd.mod_step && k_reg == KW'(1))
            rem_reg <= rem_reg - qt;
    end

    // probe step: next offset is n or n*n, both kept modulo the table size
    always_comb
    begin
        nmod_next = modadd(nmod_reg, SW'(1));
        sq_next   = modadd(sq_reg, odd_reg);
        odd_next  = modadd(odd_reg, TWO_MOD);
        key_next  = modadd(key_reg, hash_mode_reg ? sq_next : nmod_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            key_reg  <= hash_new;
            n_reg    <= '0;
            nmod_reg <= '0;
            sq_reg   <= '0;
            odd_reg  <= SW'(1);
        end
        else if (cmd.probe_wr && rd_used)
        begin
            key_reg  <= key_next;
            n_reg    <= n_reg + 1'b1;
            nmod_reg <= nmod_next;
            sq_reg   <= sq_next;
            odd_reg  <= odd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_init)
            clr_addr_reg <= '0;
        else if (cmd.clr_wr)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    assign rd_used = rd_data_reg[RW-1];
    assign rd_coll = rd_data_reg[NB +: 16];
    assign rd_name = rd_data_reg[NB-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_NAME_BYTES; i++)
            new_name[8*i +: 8] = (i < 32'(len_reg)) ? buf_reg[8*i +: 8] : 8'd0;
        sel_byte = 8'd0;
        for (int i = 0; i < MAX_NAME_BYTES; i++)
            if (32'(pos_reg) == i)
                sel_byte = rd_name[8*i +: 8];
    end

    always_comb
    begin
        mem_we    = cmd.clr_wr || cmd.probe_wr;
        mem_waddr = cmd.clr_wr ? clr_addr_reg : key_reg;
        priority if (cmd.clr_wr)
            mem_wdata = '0;
        else if (rd_used)
            mem_wdata = {1'b1, rd_coll + 16'd1, rd_name};
        else
            mem_wdata = {1'b1, rd_coll, new_name};
        mem_raddr = cmd.slot_rd ? SW'(rslot_reg) : key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        if (cmd.probe_rd || cmd.slot_rd)
            rd_data_reg <= slot_mem[mem_raddr];
    end

    assign rd_in_range = (32'(rslot_reg) < TABLE_SLOTS);

    always_ff @(posedge clk)
    begin
        priority if (cmd.res_too_long)
            pend_reg <= '{status: oahi_pkg::STAT_TOO_LONG, default: '0};
        else if (cmd.res_ins)
            pend_reg <= '{status: oahi_pkg::STAT_INSERTED, slot: 10'(key_reg),
                          probes: 10'(n_reg), default: '0};
        else if (cmd.res_full)
            pend_reg <= '{status: oahi_pkg::STAT_FULL, probes: 10'(TABLE_SLOTS),
                          default: '0};
        else if (cmd.res_read)
        begin
            pend_reg.status     <= oahi_pkg::STAT_DONE;
            pend_reg.slot       <= rslot_reg;
            pend_reg.probes     <= '0;
            pend_reg.occupied   <= rd_in_range & rd_used;
            pend_reg.collisions <= rd_in_range ? rd_coll : 16'd0;
            pend_reg.name_byte  <= (rd_in_range && 32'(pos_reg) < MAX_NAME_BYTES)
                                   ? sel_byte : 8'd0;
        end
        else if (cmd.res_clear)
            pend_reg <= '{status: oahi_pkg::STAT_DONE, default: '0};
        if (cmd.out_load)
            out_reg <= pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        sts.mod_done   = (k_reg == '0);
        sts.name_last  = last_reg;
        sts.too_long   = (len_reg > LW'(MAX_NAME_BYTES));
        sts.slot_free  = !rd_used;
        sts.probe_last = (n_reg == NW'(TABLE_SLOTS - 1));
        sts.clr_last   = (clr_addr_reg == SW'(TABLE_SLOTS - 1));
        sts.out_free   = !out_valid_reg || !result_stall;
    end

endmodule

// ===== hw/rtl/oahi_chk.sv =====
// Port-level checker for open_address_hash_insert, attached by bind.
// Depends on oahi_pkg.
module oahi_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input oahi_pkg::result_t result
);

    // hold a stalled result word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result word dropped");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result word changed");

    a_done_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == oahi_pkg::STAT_DONE |-> result.probes == 10'd0)
        else $error("read or clear result reports probes");

    a_insert_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != oahi_pkg::STAT_DONE
        |-> !result.occupied && result.collisions == 16'd0 && result.name_byte == 8'd0)
        else $error("insert result carries read fields");

    a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == oahi_pkg::STAT_TOO_LONG
        |-> result.slot == 10'd0 && result.probes == 10'd0)
        else $error("rejected name reports a slot");

endmodule

bind open_address_hash_insert oahi_chk u_oahi_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== dv/oahi_checker.sv =====
// Checker for the open-address hash insert block: watches the item and result
// channels, keeps its own copy of the table and compares every result word.
// Depends on oahi_pkg.
`timescale 1ns / 100ps

module oahi_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  oahi_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  oahi_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                insert_count,
    output int                full_count
);

    localparam int TABLE_SLOTS    = oahi_pkg::TABLE_SLOTS;
    localparam int MAX_NAME_BYTES = oahi_pkg::MAX_NAME_BYTES;

    logic              squared_mode;
    logic              used_tbl [TABLE_SLOTS];
    logic [15:0]       coll_tbl [TABLE_SLOTS];
    logic [7:0]        name_tbl [TABLE_SLOTS][MAX_NAME_BYTES];
    int                acc_hash;
    int                acc_len;
    logic [7:0]        acc_bytes [MAX_NAME_BYTES];
    oahi_pkg::result_t expected_words [$];

    function automatic void wipe_table();
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            used_tbl[s] = 1'b0;
            coll_tbl[s] = '0;
            for (int b = 0; b < MAX_NAME_BYTES; b++)
                name_tbl[s][b] = '0;
        end
    endfunction

    // Work out the result word (if any) of one accepted item.
    function automatic bit predict_table(input oahi_pkg::item_t it,
                                         output oahi_pkg::result_t r);
        longint h;
        int key;
        int n;
        r = '0;
        unique case (oahi_pkg::func_t'(it.func))
            oahi_pkg::FUNC_NAME:
            begin
                h = acc_hash;
                h = squared_mode ? (it.name_char + h * h) % TABLE_SLOTS
                                 : (it.name_char + h) % TABLE_SLOTS;
                acc_hash = int'(h);
                if (acc_len < MAX_NAME_BYTES)
                    acc_bytes[acc_len] = it.name_char;
                if (acc_len <= MAX_NAME_BYTES)
                    acc_len++;
                if (!it.last)
                    return 0;
                if (acc_len > MAX_NAME_BYTES)
                    r.status = oahi_pkg::STAT_TOO_LONG;
                else
                begin
                    key = acc_hash % TABLE_SLOTS;
                    n = 0;
                    r.status = oahi_pkg::STAT_FULL;
                    r.probes = 10'(TABLE_SLOTS);
                    while (n < TABLE_SLOTS)
                    begin
                        if (!used_tbl[key])
                        begin
                            used_tbl[key] = 1'b1;
                            for (int b = 0; b < MAX_NAME_BYTES; b++)
                                name_tbl[key][b] = (b < acc_len) ? acc_bytes[b] : 8'd0;
                            r.status = oahi_pkg::STAT_INSERTED;
                            r.slot = 10'(key);
                            r.probes = 10'(n);
                            break;
                        end
                        coll_tbl[key] = coll_tbl[key] + 16'd1;
                        n++;
                        if (squared_mode)
                            key = int'((longint'(n) * n + key) % TABLE_SLOTS);
                        else
                            key = (n + key) % TABLE_SLOTS;
                    end
                    if (r.status == oahi_pkg::STAT_INSERTED)
                        insert_count++;
                    else
                        full_count++;
                end
                acc_hash = 0;
                acc_len = 0;
                return 1;
            end
            oahi_pkg::FUNC_READ:
            begin
                r.status = oahi_pkg::STAT_DONE;
                r.slot = it.read_slot;
                if (it.read_slot < TABLE_SLOTS)
                begin
                    r.occupied = used_tbl[it.read_slot];
                    r.collisions = coll_tbl[it.read_slot];
                    if (it.char_pos < MAX_NAME_BYTES)
                        r.name_byte = name_tbl[it.read_slot][it.char_pos];
                end
                return 1;
            end
            oahi_pkg::FUNC_CLEAR:
            begin
                wipe_table();
                r.status = oahi_pkg::STAT_DONE;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        oahi_pkg::result_t r;
        oahi_pkg::result_t e;
        if (!rst_n)
        begin
            squared_mode = 1'b0;
            wipe_table();
            acc_hash = 0;
            acc_len = 0;
            expected_words.delete();
            fail_count = 0;
            insert_count = 0;
            full_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
                squared_mode = cfg_data;
            if (item_valid && !item_stall && predict_table(item, r))
                expected_words.push_back(r);
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word %h", $time, result);
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (result.status !== e.status || result.slot !== e.slot
                        || result.probes !== e.probes || result.occupied !== e.occupied
                        || result.collisions !== e.collisions
                        || result.name_byte !== e.name_byte)
                    begin
                        fail_count++;
                        $display("%0t: expected st=%0d slot=%0d pr=%0d occ=%0d col=%0d b=%0d",
                                 $time, e.status, e.slot, e.probes, e.occupied,
                                 e.collisions, e.name_byte);
                        $display("%0t: actual   st=%0d slot=%0d pr=%0d occ=%0d col=%0d b=%0d",
                                 $time, result.status, result.slot, result.probes,
                                 result.occupied, result.collisions, result.name_byte);
                    end
                end
            end
            pending_count = expected_words.size();
        end
    end
endmodule

// ===== dv/tb.sv =====
// Top of the open-address hash insert testbench: clock, reset, stimulus and
// verdict. Depends on oahi_pkg, open_address_hash_insert and oahi_checker.
`timescale 1ns / 100ps

module tb;

    localparam int SLOTS = oahi_pkg::TABLE_SLOTS;
    localparam int CYCLE_LIMIT = 10000000;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    oahi_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    oahi_pkg::result_t result;
    logic              cfg_we;
    logic              cfg_data;
    int                fail_count;
    int                pending_count;
    int                insert_count;
    int                full_count;
    int                cycle_count;
    int                items_sent;
    bit                hold_results;
    bit                stim_done;

    open_address_hash_insert i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    oahi_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .insert_count(insert_count), .full_count(full_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random stall per word, or a long hold when asked.
    initial
    begin
        int gap;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_results = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stim_done || $urandom_range(0, 4) == 0)
                gap = 0;
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    int idle_max = 12;

    function automatic oahi_pkg::item_t rand_word(input oahi_pkg::func_t f);
        oahi_pkg::item_t w;
        w.func      = f;
        w.name_char = 8'($urandom);
        w.last      = 1'($urandom);
        w.read_slot = 10'($urandom);
        w.char_pos  = 4'($urandom);
        return w;
    endfunction

    // Leaves valid high after the accepting edge; the next call or a drain
    // drops or replaces the word at this falling edge.
    task automatic send_word(input oahi_pkg::item_t w);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do @(posedge clk); while (item_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] c, input logic lst);
        oahi_pkg::item_t w;
        w = rand_word(oahi_pkg::FUNC_NAME);
        w.name_char = c;
        w.last = lst;
        send_word(w);
    endtask

    task automatic send_name(input int len, input int alphabet);
        for (int k = 0; k < len; k++)
            send_byte(8'($urandom_range(1, alphabet)), k == len - 1);
    endtask

    task automatic send_read(input logic [9:0] s, input logic [3:0] p);
        oahi_pkg::item_t w;
        w = rand_word(oahi_pkg::FUNC_READ);
        w.read_slot = s;
        w.char_pos = p;
        send_word(w);
    endtask

    task automatic send_clear();
        send_word(rand_word(oahi_pkg::FUNC_CLEAR));
    endtask

    // Wait out all results, then the block's tail, before touching the register.
    task automatic drain_and_set(input logic m);
        item_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        oahi_pkg::item_t w;
        int pick;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        hold_results = 1'b0;
        stim_done = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, zero byte, too long, ignored function, odd reads.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_name(9, 255);
        send_name(10, 255);
        send_name(14, 255);
        w = '1;
        w.func = oahi_pkg::FUNC_NOP;
        send_word(w);
        send_read(10'd0, 4'd0);
        send_read(10'd255, 4'd15);
        send_read(10'd540, 4'd8);
        send_read(10'd541, 4'd0);
        send_read(10'h3FF, 4'd9);
        send_byte(8'h41, 1'b0);
        send_read(10'd0, 4'd0);
        send_clear();
        send_byte(8'h42, 1'b1);
        drain_and_set(1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_name(3, 255);
        send_read(10'd0, 4'd1);
        drain_and_set(1'b0);
        // Mode change between bytes of one name.
        send_byte(8'h33, 1'b0);
        drain_and_set(1'b1);
        send_byte(8'h44, 1'b1);

        // Long receiver hold while the sender keeps going.
        hold_results = 1'b1;
        idle_max = 0;
        for (int k = 0; k < 30; k++)
            send_name(2, 255);
        idle_max = 12;

        // Random phases; small alphabets cause many collisions, and one phase
        // fills the table to reach the no-free-slot case.
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_set(ph[0]);
            if (ph == 2)
            begin
                idle_max = 1;
                for (int k = 0; k < 560; k++)
                    send_name(1, 255);
                idle_max = 12;
            end
            for (int k = 0; k < 33; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_name($urandom_range(1, 9), (ph < 3) ? 4 : 255);
                else if (pick < 80)
                    send_name($urandom_range(10, 12), 255);
                else if (pick < 97)
                    send_read(10'($urandom_range(0, SLOTS - 1)), 4'($urandom_range(0, 9)));
                else if (pick < 98)
                    send_clear();
                else
                    send_word(rand_word(oahi_pkg::FUNC_NOP));
            end
        end

        item_valid <= 1'b0;
        stim_done = 1'b1;
        while (pending_count != 0)
            @(negedge clk);
        repeat (2000) @(negedge clk);
        $display("sent %0d words: %0d inserts, %0d full-table rejects, both hash modes",
                 items_sent, insert_count, full_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
